### src/bsd_pkg.sv
// Shared types and constants of the 2x2 box-sum downsampler.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package bsd_pkg;

  // geometry
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int COMPONENTS    = 3;
  localparam int MAX_HEIGHT    = 8192;
  localparam int BND_W         = 14;   // holds any bounded width or height
  localparam int ROW_W         = 13;
  localparam int SUM_W         = 16;
  localparam int SAMPLE_W      = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 14;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RGB_MODE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_SIGNED   = 2'd3;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 14'd480;

  // register file contents
  typedef struct packed {
    logic [WIDTH_W-1:0]  source_width;
    logic [HEIGHT_W-1:0] source_height;
    logic                rgb_mode;
    logic                wide_signed_source;
  } cfg_t;

  // line store operation for the sample being accepted
  typedef struct packed {
    logic             wr;     // top row of a block: store the pair sum
    logic             rd;     // bottom row: fetch the stored pair sum
    logic [SUM_W-1:0] pair;
    logic [1:0]       comp;
    logic             eor;
    logic             eof;
  } scan_op_t;

endpackage

`default_nettype wire

### src/bsd_if.sv
// Valid/ready channel interfaces: source samples, block sums, register writes.
// Depends on bsd_pkg for the payload widths.
`default_nettype none

interface bsd_sample_if;
  logic                          valid;
  logic                          ready;
  logic [bsd_pkg::SAMPLE_W-1:0]  sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bsd_sum_if;
  logic                              valid;
  logic                              ready;
  logic signed [bsd_pkg::SUM_W-1:0]  block_sum;
  logic [1:0]                        component;
  logic                              end_of_row;
  logic                              end_of_frame;
  modport source (output valid, output block_sum, output component,
                  output end_of_row, output end_of_frame, input ready);
  modport sink   (input valid, input block_sum, input component,
                  input end_of_row, input end_of_frame, output ready);
endinterface

interface bsd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bsd_pkg::CFG_IDX_W-1:0]     index;
  logic [bsd_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/box_sum_downsample_2x2_top.sv
// 2x2 box-sum downsampler (binning): takes one source sample per request in
// raster order, gray or three interleaved components, and returns one wrapped
// 16-bit block sum per component at each odd column of each odd row. A new
// sample is accepted every clock cycle while the output side keeps up; the
// figure is set by the single-port line store, which each sample touches at
// most once (a write on top rows, a read on bottom rows). Results pass stage 1
// and the output register. The line store holds MAX_WIDTH/2*3 16-bit words
// with no clearing pass after reset: every entry read in a bottom row was
// written in the row above. The user must write registers only while the
// block is idle; it does not enforce this. Writes apply from the next sample.
// Depends on bsd_pkg, bsd_if, bsd_cfg_regs, bsd_scan and bsd_line_mem.
`default_nettype none

module box_sum_downsample_2x2_top #(
  parameter int MAX_WIDTH = bsd_pkg::MAX_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  bsd_sample_if.sink samples,
  bsd_sum_if.source  sums,
  bsd_cfg_if.sink    cfg
);

  localparam int DEPTH = MAX_WIDTH / 2 * bsd_pkg::COMPONENTS;
  localparam int AW    = $clog2(DEPTH);

  bsd_pkg::cfg_t             regs;
  bsd_pkg::scan_op_t         op;
  logic [AW-1:0]             addr;
  logic [bsd_pkg::SUM_W-1:0] rdata;
  logic                      accept_in, mem_wr, mem_rd;

  // stage 1: waiting for line store read data
  logic                      s1_valid;
  logic [bsd_pkg::SUM_W-1:0] s1_pair;
  logic [1:0]                s1_comp;
  logic                      s1_eor, s1_eof;

  // output register
  logic                      o_valid;
  logic [bsd_pkg::SUM_W-1:0] o_sum;
  logic [1:0]                o_comp;
  logic                      o_eor, o_eof;

  logic                      out_free, s1_adv;

  bsd_cfg_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bsd_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .advance (accept_in),
    .sample  (samples.sample),
    .op      (op),
    .addr    (addr)
  );

  bsd_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .wr_en (mem_wr),
    .rd_en (mem_rd),
    .addr  (addr),
    .wdata (op.pair),
    .rdata (rdata)
  );

  // handshake and store access
  assign out_free      = !o_valid || sums.ready;
  assign s1_adv        = s1_valid && out_free;
  assign samples.ready = !s1_valid || out_free;
  assign accept_in     = samples.valid && samples.ready;
  assign mem_wr        = accept_in && op.wr;
  assign mem_rd        = accept_in && op.rd;

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (mem_rd) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (mem_rd) begin
      s1_pair <= op.pair;
      s1_comp <= op.comp;
      s1_eor  <= op.eor;
      s1_eof  <= op.eof;
    end
  end

  // output control
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= 1'b1;
    end else if (sums.ready) begin
      o_valid <= 1'b0;
    end
  end

  // output payload: stored top pair plus bottom pair
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_sum  <= rdata + s1_pair;
      o_comp <= s1_comp;
      o_eor  <= s1_eor;
      o_eof  <= s1_eof;
    end
  end

  assign sums.valid        = o_valid;
  assign sums.block_sum    = o_sum;
  assign sums.component    = o_comp;
  assign sums.end_of_row   = o_eor;
  assign sums.end_of_frame = o_eof;

  // checks
  a_mem_one_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_rd && mem_wr))
    else $error("line store read and write in one cycle");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && o_valid && !sums.ready |-> !accept_in)
    else $error("sample accepted with both result stages stalled");

  a_eof_has_eor: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_eof |-> o_eor)
    else $error("frame end without row end");

  a_comp_range: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> o_comp != 2'd3)
    else $error("component index out of range");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    o_valid && sums.ready && !s1_valid |=> !o_valid)
    else $error("result repeated after delivery");

endmodule

`default_nettype wire

### src/bsd_cfg_regs.sv
// Configuration registers written through the register request channel.
// Depends on bsd_pkg and bsd_cfg_if.
`default_nettype none

module bsd_cfg_regs (
  input  wire logic      clk,
  input  wire logic      rst,
  bsd_cfg_if.sink        cfg,
  output bsd_pkg::cfg_t  regs
);

  bsd_pkg::cfg_t regs_next;

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register decode
  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      case (cfg.index)
        bsd_pkg::REG_SOURCE_WIDTH:
          regs_next.source_width = cfg.data[bsd_pkg::WIDTH_W-1:0];
        bsd_pkg::REG_SOURCE_HEIGHT:
          regs_next.source_height = cfg.data[bsd_pkg::HEIGHT_W-1:0];
        bsd_pkg::REG_RGB_MODE:
          regs_next.rgb_mode = cfg.data[0];
        bsd_pkg::REG_WIDE_SIGNED:
          regs_next.wide_signed_source = cfg.data[0];
        default: regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.source_width       <= bsd_pkg::WIDTH_RESET;
      regs.source_height      <= bsd_pkg::HEIGHT_RESET;
      regs.rgb_mode           <= 1'b0;
      regs.wide_signed_source <= 1'b0;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

`default_nettype wire

### src/bsd_line_mem.sv
// Single-port line store of horizontal pair sums, registered read data.
// Depends on bsd_pkg for the word width.
`default_nettype none

module bsd_line_mem #(
  parameter int DEPTH = bsd_pkg::MAX_WIDTH_DEF / 2 * bsd_pkg::COMPONENTS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic                      rd_en,
  input  wire logic [AW-1:0]             addr,
  input  wire logic [bsd_pkg::SUM_W-1:0] wdata,
  output logic      [bsd_pkg::SUM_W-1:0] rdata
);

  logic [bsd_pkg::SUM_W-1:0] mem [DEPTH];

  // one access per cycle, read or write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### src/bsd_scan.sv
// Raster position counters, pair-hold registers and line store addressing.
// Depends on bsd_pkg for the config and operation structs.
`default_nettype none

module bsd_scan #(
  parameter int MAX_WIDTH = bsd_pkg::MAX_WIDTH_DEF,
  parameter int AW        = $clog2(MAX_WIDTH / 2 * bsd_pkg::COMPONENTS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bsd_pkg::cfg_t                cfg,
  input  wire logic                         advance,
  input  wire logic [bsd_pkg::SAMPLE_W-1:0] sample,
  output bsd_pkg::scan_op_t                 op,
  output logic      [AW-1:0]                addr
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int BW    = bsd_pkg::BND_W;

  logic [COL_W-1:0]          col;
  logic [1:0]                comp_cnt;
  logic [bsd_pkg::ROW_W-1:0] row;
  logic [bsd_pkg::SUM_W-1:0] pair_hold [bsd_pkg::COMPONENTS];

  logic [BW-1:0]             w_even, h_even, width_eff, height_eff;
  logic [1:0]                comp;
  logic                      last_comp, last_col, last_row;
  logic [bsd_pkg::SUM_W-1:0] smp;
  logic [AW-1:0]             half;

  // bounded frame size, position flags, store address
  always_comb begin
    w_even = {2'b00, cfg.source_width[bsd_pkg::WIDTH_W-1:1], 1'b0};
    if (w_even < BW'(2)) begin
      width_eff = BW'(2);
    end else if (w_even > BW'(MAX_WIDTH)) begin
      width_eff = BW'(MAX_WIDTH);
    end else begin
      width_eff = w_even;
    end
    h_even = {cfg.source_height[bsd_pkg::HEIGHT_W-1:1], 1'b0};
    if (h_even < BW'(2)) begin
      height_eff = BW'(2);
    end else if (h_even > BW'(bsd_pkg::MAX_HEIGHT)) begin
      height_eff = BW'(bsd_pkg::MAX_HEIGHT);
    end else begin
      height_eff = h_even;
    end

    comp      = (comp_cnt == 2'd3) ? 2'd0 : comp_cnt;
    last_comp = !cfg.rgb_mode || (comp == 2'd2);
    last_col  = ((BW + 1)'(col) + (BW + 1)'(1)) >= {1'b0, width_eff};
    last_row  = ((BW + 1)'(row) + (BW + 1)'(1)) >= {1'b0, height_eff};

    // byte samples are zero-extended, wide samples pass as they are
    smp = cfg.wide_signed_source ? sample : {8'h00, sample[7:0]};

    half = AW'(col >> 1);
    addr = (half << 1) + half + AW'(comp);

    op.wr   = col[0] && !row[0];
    op.rd   = col[0] && row[0];
    op.pair = pair_hold[comp] + smp;
    op.comp = comp;
    op.eor  = last_col && last_comp;
    op.eof  = last_col && last_comp && last_row;
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      comp_cnt <= 2'd0;
      row      <= '0;
    end else if (advance) begin
      if (last_comp) begin
        comp_cnt <= 2'd0;
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end else begin
        comp_cnt <= comp + 2'd1;
      end
    end
  end

  // left sample of each horizontal pair, per component
  always_ff @(posedge clk) begin
    if (advance && !col[0]) begin
      pair_hold[comp] <= smp;
    end
  end

endmodule

`default_nettype wire

### tb/sv/box_sum_downsample_2x2_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of box_sum_downsample_2x2_top: streams whole frames of random and
// corner samples under varied geometry and idle mixes, and checks every block sum.
// Depends on bsd_pkg, the bsd_if channel interfaces and the block's RTL.

module box_sum_downsample_2x2_top_test;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TIMEOUT_CYCLES = 600_000;
  localparam int STORE_WORDS    = bsd_pkg::MAX_WIDTH_DEF / 2 * bsd_pkg::COMPONENTS;
  localparam int PHASE_SAMPLES  = 400;
  localparam int MAX_PRINTED    = 30;

  typedef struct packed {
    logic signed [bsd_pkg::SUM_W-1:0] block_sum;
    logic [1:0]                       component;
    logic                             end_of_row;
    logic                             end_of_frame;
  } binned_t;

  // binning predictor plus the queue of block sums still owed by the block
  class binning_scoreboard;
    bit [bsd_pkg::WIDTH_W-1:0]  width_reg  = bsd_pkg::WIDTH_RESET;
    bit [bsd_pkg::HEIGHT_W-1:0] height_reg = bsd_pkg::HEIGHT_RESET;
    bit                         rgb        = 1'b0;
    bit                         wide       = 1'b0;
    bit [bsd_pkg::SUM_W-1:0]    pair_store [STORE_WORDS];
    bit [bsd_pkg::SUM_W-1:0]    pair_hold [bsd_pkg::COMPONENTS];
    int unsigned                col, comp_idx, row;
    binned_t                    sums_due [$];
    int unsigned                errors, n_samples, n_sums, n_row_ends, n_frame_ends, n_writes;

    function int unsigned even_clamp(int unsigned v, int unsigned hi);
      v = v & ~32'd1;
      if (v < 2) v = 2;
      if (v > hi) v = hi;
      return v;
    endfunction

    function int unsigned frame_len();
      return even_clamp(width_reg, bsd_pkg::MAX_WIDTH_DEF) *
             even_clamp(height_reg, bsd_pkg::MAX_HEIGHT) *
             (rgb ? bsd_pkg::COMPONENTS : 1);
    endfunction

    function int unsigned pending();
      return sums_due.size();
    endfunction

    function void load_reg(logic [bsd_pkg::CFG_IDX_W-1:0] idx,
                           logic [bsd_pkg::CFG_DATA_W-1:0] value);
      n_writes++;
      case (idx)
        bsd_pkg::REG_SOURCE_WIDTH:  width_reg  = value[bsd_pkg::WIDTH_W-1:0];
        bsd_pkg::REG_SOURCE_HEIGHT: height_reg = value[bsd_pkg::HEIGHT_W-1:0];
        bsd_pkg::REG_RGB_MODE:      rgb        = value[0];
        bsd_pkg::REG_WIDE_SIGNED:   wide       = value[0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [bsd_pkg::SAMPLE_W-1:0] raw);
      int unsigned w, h, ncomp, c, slot;
      bit          last_comp, last_col, last_row;
      bit [bsd_pkg::SUM_W-1:0] s, pair;
      binned_t     due;
      w = even_clamp(width_reg, bsd_pkg::MAX_WIDTH_DEF);
      h = even_clamp(height_reg, bsd_pkg::MAX_HEIGHT);
      ncomp = rgb ? bsd_pkg::COMPONENTS : 1;
      c = comp_idx % bsd_pkg::COMPONENTS;
      last_comp = (c + 1 >= ncomp);
      last_col = (col + 1 >= w);
      last_row = (row + 1 >= h);
      s = wide ? raw : {8'h00, raw[7:0]};
      slot = (col >> 1) * bsd_pkg::COMPONENTS + c;
      if (slot >= STORE_WORDS) slot = STORE_WORDS - 1;
      n_samples++;

      // even column: hold the left sample; odd column: form the pair
      if (!col[0]) begin
        pair_hold[c] = s;
      end else begin
        pair = pair_hold[c] + s;
        if (!row[0]) begin
          pair_store[slot] = pair;
        end else begin
          due.block_sum = pair_store[slot] + pair;
          due.component = 2'(c);
          due.end_of_row = last_col && last_comp;
          due.end_of_frame = due.end_of_row && last_row;
          sums_due.push_back(due);
        end
      end

      // raster position advance, wrapping anything at or past its bound
      if (last_comp) begin
        comp_idx = 0;
        if (last_col) begin
          col = 0;
          row = last_row ? 0 : row + 1;
        end else begin
          col++;
        end
      end else begin
        comp_idx = c + 1;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("ERROR: %s", msg);
    endtask

    task check_sum(binned_t got);
      binned_t due;
      if (sums_due.size() == 0) begin
        report($sformatf("block sum %0d arrived with no request pending",
                         $signed(got.block_sum)));
        return;
      end
      due = sums_due.pop_front();
      n_sums++;
      n_row_ends += due.end_of_row;
      n_frame_ends += due.end_of_frame;
      if (got.block_sum !== due.block_sum)
        report($sformatf("sum %0d: block_sum %0d, expected %0d", n_sums,
                         $signed(got.block_sum), $signed(due.block_sum)));
      if (got.component !== due.component)
        report($sformatf("sum %0d: component %0d, expected %0d", n_sums,
                         got.component, due.component));
      if (got.end_of_row !== due.end_of_row)
        report($sformatf("sum %0d: end_of_row %0b, expected %0b", n_sums,
                         got.end_of_row, due.end_of_row));
      if (got.end_of_frame !== due.end_of_frame)
        report($sformatf("sum %0d: end_of_frame %0b, expected %0b", n_sums,
                         got.end_of_frame, due.end_of_frame));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned src_gap_pct = 0;
  int unsigned sink_stall_pct = 0;

  bsd_sample_if samples ();
  bsd_sum_if    sums ();
  bsd_cfg_if    cfg ();

  binning_scoreboard sb = new();

  box_sum_downsample_2x2_top dut (
    .clk(clk),
    .rst(rst),
    .samples(samples),
    .sums(sums),
    .cfg(cfg)
  );

  always #CLK_HALF clk = ~clk;

  // watch all three channels at the rising edge
  always @(posedge clk) begin : watch
    binned_t got;
    if (!rst) begin
      if (cfg.valid && cfg.ready) sb.load_reg(cfg.index, cfg.data);
      if (samples.valid && samples.ready) sb.note_sample(samples.sample);
      if (sums.valid && sums.ready) begin
        got.block_sum = sums.block_sum;
        got.component = sums.component;
        got.end_of_row = sums.end_of_row;
        got.end_of_frame = sums.end_of_frame;
        sb.check_sum(got);
      end
    end
  end

  // output back-pressure
  initial begin
    sums.ready <= 1'b0;
    forever begin
      @(negedge clk);
      sums.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic logic [bsd_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'h00FF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one request on the sample channel; valid stays up after acceptance
  task automatic send_sample(input logic [bsd_pkg::SAMPLE_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < src_gap_pct) begin
      samples.valid <= 1'b0;
      @(negedge clk);
    end
    samples.valid <= 1'b1;
    samples.sample <= value;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
  endtask

  task automatic send_samples(input int unsigned n);
    repeat (n) send_sample(pick_sample());
  endtask

  task automatic run_frames(input int unsigned n);
    send_samples(n * sb.frame_len());
  endtask

  // stop sending and wait for every owed block sum
  task automatic hold_off();
    @(negedge clk);
    samples.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // idle point: owed sums in, then room for samples still in the pipe
  task automatic settle();
    hold_off();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bsd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bsd_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // full geometry load; unused upper data bits sometimes carry junk
  task automatic configure(input int unsigned w, input int unsigned h,
                           input bit rgb_on, input bit wide_on);
    logic [bsd_pkg::CFG_DATA_W-1:0] junk;
    junk = $urandom_range(1) ? 16'($urandom) : 16'h0000;
    settle();
    write_reg(bsd_pkg::REG_SOURCE_WIDTH, {junk[15:12], w[11:0]});
    write_reg(bsd_pkg::REG_SOURCE_HEIGHT, {junk[15:14], h[13:0]});
    write_reg(bsd_pkg::REG_RGB_MODE, {junk[15:1], rgb_on});
    write_reg(bsd_pkg::REG_WIDE_SIGNED, {junk[15:1], wide_on});
  endtask

  // random geometry, whole frames, an occasional pause mid-frame
  task automatic random_phase(input int unsigned quota);
    int unsigned goal, w, h, lead;
    goal = sb.n_samples + quota;
    while (sb.n_samples < goal) begin
      case ($urandom_range(0, 9))
        0: w = $urandom_range(0, 1);
        1: w = $urandom_range(13, 32);
        default: w = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 9))
        0: h = $urandom_range(0, 1);
        1: h = $urandom_range(7, 10);
        default: h = $urandom_range(2, 6);
      endcase
      configure(w, h, 1'($urandom), 1'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        lead = $urandom_range(1, sb.frame_len() - 1);
        send_samples(lead);
        hold_off();
        send_samples(sb.frame_len() - lead);
      end else begin
        run_frames($urandom_range(1, 2));
      end
    end
  endtask

  initial begin
    logic [bsd_pkg::SAMPLE_W-1:0] wide_corners [12] = '{
      16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
      16'h8000, 16'h8000, 16'h8000, 16'h8000,
      16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF};
    logic [bsd_pkg::SAMPLE_W-1:0] byte_corners [8] = '{
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'h0000, 16'h00FF, 16'hFF00, 16'h1234};
    int unsigned lead;

    samples.valid <= 1'b0;
    samples.sample <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // signed 16-bit corners: positive and negative wrap
    configure(2, 2, 1'b0, 1'b1);
    foreach (wide_corners[i]) send_sample(wide_corners[i]);
    // byte samples ignore the upper byte
    configure(2, 2, 1'b0, 1'b0);
    foreach (byte_corners[i]) send_sample(byte_corners[i]);
    // three interleaved components
    configure(2, 2, 1'b1, 1'b1);
    run_frames(1);

    // height cut below the current bottom row: that row closes the frame
    configure(4, 8, 1'b0, 1'b1);
    send_samples(12);
    settle();
    write_reg(bsd_pkg::REG_SOURCE_HEIGHT, 16'd2);
    send_samples(4);

    // width cut below the current column of a top row
    configure(8, 2, 1'b0, 1'b0);
    send_samples(6);
    settle();
    write_reg(bsd_pkg::REG_SOURCE_WIDTH, 16'd4);
    send_samples(5);

    // gray mode entered mid-pixel: leftover component index wraps
    configure(4, 2, 1'b1, 1'b1);
    lead = $urandom_range(1, 2);
    send_samples(6 + lead);
    settle();
    write_reg(bsd_pkg::REG_RGB_MODE, 16'd0);
    send_samples(6);

    // size bounds: odd and out-of-range values saturate, so no row or
    // frame ends early; a later cut closes the row or frame
    configure(4095, 1, 1'b0, 1'b0);
    send_samples(40);
    settle();
    write_reg(bsd_pkg::REG_SOURCE_WIDTH, 16'd40);
    send_samples(41);
    configure(1, 16383, 1'b0, 1'b1);
    send_samples(40);
    settle();
    write_reg(bsd_pkg::REG_SOURCE_HEIGHT, 16'd2);
    send_samples(2);

    // random frames under each idle mix
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_gap_pct = 61; sink_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  sink_stall_pct = 61; end
        default: begin src_gap_pct = 28; sink_stall_pct = 28; end
      endcase
      random_phase(PHASE_SAMPLES);
    end

    settle();
    $display("covered %0d samples into %0d block sums (%0d row ends, %0d frame ends)",
             sb.n_samples, sb.n_sums, sb.n_row_ends, sb.n_frame_ends);
    $display("%0d register writes: mid-frame changes, size bounds, four idle mixes",
             sb.n_writes);
    if (sb.errors == 0)
      $display("box_sum_downsample_2x2_top test passed");
    else
      $display("box_sum_downsample_2x2_top test failed");
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("timeout with %0d block sums still owed", sb.pending());
    $display("box_sum_downsample_2x2_top test failed");
    $finish;
  end

endmodule

### box_sum_downsample_2x2_top.f
src/bsd_pkg.sv
src/bsd_if.sv
src/bsd_cfg_regs.sv
src/bsd_line_mem.sv
src/bsd_scan.sv
src/box_sum_downsample_2x2_top.sv
tb/sv/box_sum_downsample_2x2_top_test.sv
